// ----- sv/planar_packbits_row_decoder_unit_assert.svh -----
// Assertion macros shared by the decoder RTL
`ifndef PLANAR_PACKBITS_ROW_DECODER_UNIT_ASSERT_SVH
`define PLANAR_PACKBITS_ROW_DECODER_UNIT_ASSERT_SVH
// Implication checked every clock outside reset
`define PPRD_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("pprd check failed");
// Next-cycle implication
`define PPRD_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("pprd check failed");
`endif

// ----- sv/pprd_pkg.sv -----
//------------------------------------------------------------------------------
// pprd_pkg
// Shared types and constants for the planar PackBits row decoder.
//------------------------------------------------------------------------------
`default_nettype none
package pprd_pkg;
   localparam int MaxHeight = 1024;
   localparam int MaxStride = 4096;
   localparam int MaxPlanes = 4;
   localparam int TblDepth  = MaxPlanes * MaxHeight;
   localparam int TblAw     = $clog2(TblDepth);

   localparam logic [1:0] CSR_DEPTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_STRIDE = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [23:0] packet_length;
   } item_type;

   typedef struct packed {
      logic        write_valid;
      logic [1:0]  plane;
      logic [9:0]  row;
      logic [11:0] column;
      logic [7:0]  run_length;
      logic [7:0]  pixel_value;
      logic        packet_end;
      logic [1:0]  status;
   } rsp_type;
endpackage
`default_nettype wire

// ----- sv/pprd_ram.sv -----
//------------------------------------------------------------------------------
// pprd_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module pprd_ram #(
   parameter int Width = 16,
   parameter int Depth = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- sv/pprd_front.sv -----
//------------------------------------------------------------------------------
// pprd_front
// Input queue: two-entry FIFO between the byte channel and the decoder.
//------------------------------------------------------------------------------
`default_nettype none
module pprd_front
   import pprd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output      logic     in_ready,
   input  wire item_type in_item,
   output      logic     out_valid,
   input  wire logic     out_ready,
   output      item_type out_item
);
   item_type   q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = q_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) q_ff[wp_ff] <= in_item;
   end

   `include "planar_packbits_row_decoder_unit_assert.svh"
   `PPRD_ASSERT_IMPL(a_no_ovf, clock, reset, cnt_ff == 2'd2, !in_ready)
   `PPRD_ASSERT_NEXT(a_cnt_full, clock, reset, push && !pop && cnt_ff == 2'd1, cnt_ff == 2'd2)
   `PPRD_ASSERT_IMPL(a_cnt_rng, clock, reset, 1'b1, cnt_ff != 2'd3)
endmodule
`default_nettype wire

// ----- sv/pprd_back.sv -----
//------------------------------------------------------------------------------
// pprd_back
// Decode engine: header check, row table load, PackBits decode, row settle.
//------------------------------------------------------------------------------
`default_nettype none
module pprd_back
   import pprd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [1:0]  cfg_depth,
   input  wire logic [10:0] cfg_height,
   input  wire logic [12:0] cfg_width,
   input  wire logic [12:0] cfg_stride,
   input  wire logic        in_valid,
   output      logic        in_ready,
   input  wire item_type    in_item,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      rsp_type     rsp_data
);
   typedef enum logic [2:0] {
      PH_HEADER, PH_TABLE, PH_COUNT, PH_LITERAL, PH_REPEAT, PH_DONE, PH_FAIL
   } phase_type;
   // LOAD: table read in flight; SETTLE: check budget after load
   typedef enum logic [1:0] {S_RUN, S_LOAD, S_SETTLE} seq_type;

   phase_type   ph_ff;
   seq_type     sq_ff;
   logic [23:0] pos_ff;
   logic [1:0]  pl_ff;
   logic [9:0]  row_ff;
   logic [12:0] col_ff;
   logic [31:0] bud_ff;
   logic [7:0]  lit_ff;
   logic [7:0]  hi_ff;
   logic [1:0]  err_ff;
   logic        rv_ff;
   logic        scan_ff;
   rsp_type     rsp_ff;
   logic [23:0] need_ff;

   logic [2:0]  nplanes;
   logic [10:0] eh;
   logic [12:0] es;
   logic [15:0] rd_data;
   logic        wr_en;
   logic [TblAw-1:0] wr_addr, rd_addr;
   logic [13:0] tbl_words;

   always_comb begin
      unique case (cfg_depth)
         2'd1:    nplanes = 3'd3;
         2'd2:    nplanes = 3'd4;
         default: nplanes = 3'd1;
      endcase
      eh = (cfg_height > 11'(MaxHeight)) ? 11'(MaxHeight) : cfg_height;
      es = (cfg_stride > 13'(MaxStride)) ? 13'(MaxStride) : cfg_stride;
      tbl_words = 14'(nplanes) * 14'(eh);
   end

   // minimum size, precomputed from config; /129 as multiply by 8129 >> 20
   logic [13:0] wsum;
   logic [26:0] wprod;
   logic [6:0]  wblk;
   logic [23:0] need_full;
   always_comb begin
      wsum      = 14'(cfg_width) + 14'd128;
      wprod     = 27'(wsum) * 27'd8129;
      wblk      = wprod[26:20];
      need_full = 24'(tbl_words) * (24'd2 + 24'({wblk, 1'b0}));
   end
   always_ff @(posedge clock) begin
      need_ff <= need_full;
   end

   function automatic logic [1:0] map_plane(input logic [2:0] np, input logic [1:0] p);
      logic [1:0] r;
      if (np == 3'd1) r = 2'd0;
      else begin
         unique case (p)
            2'd0: r = 2'd2;
            2'd1: r = 2'd0;
            2'd2: r = 2'd1;
            default: r = 2'd3;
         endcase
      end
      return r;
   endfunction

   assign rd_addr = TblAw'(({12'd0, pl_ff} * 14'(eh)) + 14'(row_ff));

   pprd_ram #(.Width(16), .Depth(TblDepth)) u_tbl (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data({hi_ff, in_item.data_byte}), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [23:0] pos1;
   logic        is_end;
   assign pos1   = pos_ff + 24'd1;
   assign is_end = ({1'b0, pos1} >= ((in_item.packet_length == 24'd0) ? 25'd1 :
                                     {1'b0, in_item.packet_length})) || (pos_ff == 24'hFFFFFF);
   assign in_ready = (sq_ff == S_RUN) && (!rv_ff || rsp_ready);
   logic acc;
   assign acc   = in_valid && in_ready;
   assign wr_en = acc && ph_ff == PH_TABLE && pos_ff[0] && (pos_ff[23:13] == 11'd0);
   assign wr_addr = pos_ff[TblAw:1];

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      phase_type   ph;
      seq_type     sq;
      logic [1:0]  pl;
      logic [9:0]  rw;
      logic [12:0] col;
      logic [31:0] bud;
      logic [7:0]  lit, b;
      logic [1:0]  err;
      logic        wv, adv, ld, scan;
      logic [8:0]  cnt;
      rsp_type     o;
      if (reset) begin
         ph_ff <= PH_HEADER; sq_ff <= S_RUN; pos_ff <= '0; pl_ff <= '0; row_ff <= '0;
         col_ff <= '0; bud_ff <= '0; lit_ff <= '0; hi_ff <= '0; err_ff <= '0;
         rv_ff <= 1'b0; scan_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp_ready && !acc) rv_ff <= 1'b0;
         unique case (sq_ff)
            S_LOAD: begin
               sq_ff <= S_SETTLE;
            end
            S_SETTLE: begin
               if (!scan_ff) begin
                  bud_ff <= {16'd0, rd_data};
                  col_ff <= '0;
               end
               if (rd_data != 16'd0) begin
                  sq_ff <= S_RUN;
                  if (scan_ff) begin
                     // packet ended with a row still needing bytes
                     rsp_ff.status <= ST_TRUNC; rv_ff <= 1'b1; scan_ff <= 1'b0;
                     ph_ff <= PH_HEADER; pl_ff <= '0; row_ff <= '0;
                  end
               end else begin
                  // empty row: step to next
                  if ({1'b0, row_ff} + 11'd1 >= eh) begin
                     row_ff <= '0;
                     if ({1'b0, pl_ff} + 3'd1 >= nplanes) begin
                        sq_ff <= S_RUN;
                        if (scan_ff) begin
                           rsp_ff.status <= ST_OK; rv_ff <= 1'b1; scan_ff <= 1'b0;
                           ph_ff <= PH_HEADER; pl_ff <= '0;
                        end else begin
                           ph_ff <= PH_DONE;
                        end
                     end else begin
                        pl_ff <= pl_ff + 2'd1; sq_ff <= S_LOAD;
                     end
                  end else begin
                     row_ff <= row_ff + 10'd1; sq_ff <= S_LOAD;
                  end
               end
            end
            default: begin
               if (acc) begin
                  ph = ph_ff; pl = pl_ff; rw = row_ff; col = col_ff; bud = bud_ff;
                  lit = lit_ff; err = err_ff; b = in_item.data_byte; wv = 1'b0;
                  adv = 1'b0; ld = 1'b0; sq = S_RUN; cnt = '0;
                  o = '0;
                  if (ph == PH_HEADER) begin
                     if (in_item.packet_length < need_ff) begin
                        ph = PH_FAIL; err = ST_SHORT;
                     end else if (eh == 11'd0) ph = PH_DONE;
                     else ph = PH_TABLE;
                  end
                  priority case (ph)
                     PH_TABLE: begin
                        if (!pos_ff[0] && !is_end) hi_ff <= b;
                        if ({1'b0, pos1} >= {10'd0, tbl_words, 1'b0} ||
                            pos_ff == 24'hFFFFFF) begin
                           pl = '0; rw = '0; ph = PH_COUNT; ld = 1'b1;
                        end
                     end
                     PH_COUNT: begin
                        if (is_end) begin
                           ph = PH_FAIL; err = ST_TRUNC;
                        end else if (b <= 8'd127) begin
                           cnt = {1'b0, b} + 9'd1;
                           bud = bud - 32'(cnt) - 32'd1;
                           if (14'(col) + 14'(cnt) > 14'(es)) adv = 1'b1;
                           else if (in_item.packet_length - pos1 < 24'(cnt)) begin
                              ph = PH_FAIL; err = ST_TRUNC;
                           end else begin
                              lit = cnt[7:0]; ph = PH_LITERAL;
                           end
                        end else begin
                           cnt = 9'd257 - {1'b0, b};
                           if (14'(col) + 14'(cnt) > 14'(es)) adv = 1'b1;
                           else begin
                              lit = cnt[7:0]; ph = PH_REPEAT;
                           end
                        end
                     end
                     PH_LITERAL: begin
                        wv = 1'b1; o.run_length = 8'd1;
                        o.column = col[11:0]; col = col + 13'd1;
                        lit = lit - 8'd1;
                        if (lit == 8'd0) begin
                           ph = PH_COUNT;
                           if (bud == 32'd0) adv = 1'b1;
                        end
                     end
                     PH_REPEAT: begin
                        wv = 1'b1; o.run_length = lit; o.column = col[11:0];
                        col = col + 13'(lit); bud = bud - 32'd2; ph = PH_COUNT;
                        if (bud == 32'd0) adv = 1'b1;
                     end
                     default: ;
                  endcase
                  if (adv) begin
                     if ({1'b0, rw} + 11'd1 >= eh) begin
                        rw = '0;
                        if ({1'b0, pl} + 3'd1 >= nplanes) ph = PH_DONE;
                        else begin pl = pl + 2'd1; ld = 1'b1; ph = PH_COUNT; end
                     end else begin
                        rw = rw + 10'd1; ld = 1'b1; ph = PH_COUNT;
                     end
                  end
                  if (wv) begin
                     o.write_valid = 1'b1;
                     o.plane = map_plane(nplanes, pl_ff);
                     o.row = row_ff;
                     o.pixel_value = b;
                  end
                  o.packet_end = is_end;
                  if (is_end) begin
                     if (ph == PH_FAIL) o.status = err;
                     else if (ph == PH_DONE) o.status = ST_OK;
                     else o.status = ST_TRUNC;
                  end
                  // end with a row load pending: scan remaining rows before the beat
                  scan = is_end && ld;
                  if (wv || is_end) rsp_ff <= o;
                  rv_ff <= (wv || is_end) && !scan;
                  if (is_end) begin
                     ph_ff <= scan ? PH_COUNT : PH_HEADER; pos_ff <= '0;
                     pl_ff <= scan ? pl : 2'd0; row_ff <= scan ? rw : 10'd0;
                     col_ff <= '0; bud_ff <= '0; lit_ff <= '0; hi_ff <= '0;
                     err_ff <= '0; sq_ff <= scan ? S_LOAD : S_RUN; scan_ff <= scan;
                  end else begin
                     ph_ff <= ph; pos_ff <= pos1; pl_ff <= pl; row_ff <= rw;
                     col_ff <= ld ? 13'd0 : col; bud_ff <= bud; lit_ff <= lit;
                     err_ff <= err; if (ld) sq = S_LOAD;
                     sq_ff <= sq;
                  end
               end
            end
         endcase
      end
   end

   `include "planar_packbits_row_decoder_unit_assert.svh"
   `PPRD_ASSERT_IMPL(a_no_acc_load, clock, reset, sq_ff != S_RUN, !in_ready)
   `PPRD_ASSERT_NEXT(a_load_settle, clock, reset, sq_ff == S_LOAD, sq_ff == S_SETTLE)
   `PPRD_ASSERT_IMPL(a_wv_run, clock, reset, rv_ff && rsp_ff.write_valid, rsp_ff.run_length != 8'd0)
endmodule
`default_nettype wire

// ----- sv/planar_packbits_row_decoder_unit.sv -----
// A result beat is registered in the decode engine once its byte has left the input queue.
// Throughput: one byte per cycle while decoding and rsp_ready does not stall; each row
// change, and each empty row skipped, passes the LOAD and SETTLE table-read states.
// A packet end with a row load pending scans the remaining rows before its beat.
// Reset: synchronous, active high; packet state and config return to defaults,
// the row table is not cleared.
//------------------------------------------------------------------------------
// planar_packbits_row_decoder_unit
// Top level: config registers, input queue and PackBits decode engine.
//------------------------------------------------------------------------------
`default_nettype none
module planar_packbits_row_decoder_unit
   import pprd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_write_data,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [23:0] req_packet_length,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_write_valid,
   output      logic [1:0]  rsp_plane,
   output      logic [9:0]  rsp_row,
   output      logic [11:0] rsp_column,
   output      logic [7:0]  rsp_run_length,
   output      logic [7:0]  rsp_pixel_value,
   output      logic        rsp_packet_end,
   output      logic [1:0]  rsp_status
);
   logic [1:0]  depth_ff;
   logic [10:0] height_ff;
   logic [12:0] width_ff, stride_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= 2'd0; height_ff <= 11'd1; width_ff <= 13'd1; stride_ff <= 13'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEPTH:  depth_ff  <= csr_write_data[1:0];
            CSR_HEIGHT: height_ff <= csr_write_data[10:0];
            CSR_WIDTH:  width_ff  <= csr_write_data;
            default:    stride_ff <= csr_write_data;
         endcase
      end
   end

   item_type in_item, q_item;
   logic     q_valid, q_ready;
   rsp_type  r;
   assign in_item = '{data_byte: req_data_byte, packet_length: req_packet_length};

   pprd_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_item(in_item), .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );
   pprd_back u_back (
      .clock(clock), .reset(reset), .cfg_depth(depth_ff), .cfg_height(height_ff),
      .cfg_width(width_ff), .cfg_stride(stride_ff), .in_valid(q_valid),
      .in_ready(q_ready), .in_item(q_item), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_data(r)
   );
   assign rsp_write_valid = r.write_valid;
   assign rsp_plane       = r.plane;
   assign rsp_row         = r.row;
   assign rsp_column      = r.column;
   assign rsp_run_length  = r.run_length;
   assign rsp_pixel_value = r.pixel_value;
   assign rsp_packet_end  = r.packet_end;
   assign rsp_status      = r.status;
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the planar PackBits row decoder: builds packets
// (row-length table plus PackBits rows), predicts every beat with its own
// decoder model and compares each rsp beat field by field.
//------------------------------------------------------------------------------
`default_nettype none
module testbench;
   import pprd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      DEC_HEADER, DEC_TABLE, DEC_COUNT, DEC_LITERAL, DEC_REPEAT, DEC_DONE, DEC_FAIL
   } dec_phase_e;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_DEPTH;
   logic [12:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic [23:0] req_packet_length = 24'd1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_write_valid;
   logic [1:0]  rsp_plane;
   logic [9:0]  rsp_row;
   logic [11:0] rsp_column;
   logic [7:0]  rsp_run_length;
   logic [7:0]  rsp_pixel_value;
   logic        rsp_packet_end;
   logic [1:0]  rsp_status;

   planar_packbits_row_decoder_unit DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // decoder model state
   logic [15:0] row_len_mem [0:TblDepth-1];
   int unsigned pos_q, plane_q, row_q, col_q, budget_q, left_q, hi_q, err_q;
   dec_phase_e  phase_q;
   int unsigned cfg_depth = 0, cfg_height = 1, cfg_width = 1, cfg_stride = 1;

   rsp_type     beat_q[$];
   logic [7:0]  pkt[$];
   int          fails = 0, items_sent = 0, beats_seen = 0, writes_seen = 0;
   int          packets_sent = 0, burst_left = 0, rcyc = 0;
   int          status_seen [0:3] = '{0, 0, 0, 0};

   function automatic int unsigned plane_count();
      return cfg_depth == 1 ? 3 : (cfg_depth == 2 ? 4 : 1);
   endfunction

   function automatic int unsigned map_plane(int unsigned p);
      if (plane_count() == 1) return 0;
      case (p)
         0: return 2;
         1: return 0;
         2: return 1;
         default: return 3;
      endcase
   endfunction

   function automatic int unsigned height_eff();
      return cfg_height > MaxHeight ? MaxHeight : cfg_height;
   endfunction

   function automatic int unsigned stride_eff();
      return cfg_stride > MaxStride ? MaxStride : cfg_stride;
   endfunction

   function void fetch_row();
      int unsigned idx;
      idx = plane_q * height_eff() + row_q;
      budget_q = idx < TblDepth ? row_len_mem[idx] : 0;
      col_q = 0;
   endfunction

   function void next_row();
      row_q++;
      if (row_q >= height_eff()) begin
         row_q = 0;
         plane_q++;
         if (plane_q >= plane_count()) begin
            phase_q = DEC_DONE;
            return;
         end
      end
      phase_q = DEC_COUNT;
      fetch_row();
   endfunction

   function void skip_empty();
      while (phase_q == DEC_COUNT && budget_q == 0) next_row();
   endfunction

   function void clear_state();
      pos_q = 0; phase_q = DEC_HEADER; plane_q = 0; row_q = 0; col_q = 0;
      budget_q = 0; left_q = 0; hi_q = 0; err_q = 0;
   endfunction

   function void predict_byte(logic [7:0] b, logic [23:0] len);
      longint unsigned pos, lenl, need;
      int unsigned cnt, idx;
      bit wv, fin;
      rsp_type r;
      pos = pos_q;
      lenl = len;
      wv = 0;
      r = '0;
      if (phase_q == DEC_HEADER) begin
         need = longint'(plane_count()) * height_eff() * (2 + 2 * ((cfg_width + 128) / 129));
         if (lenl < need) begin
            phase_q = DEC_FAIL;
            err_q = ST_SHORT;
         end else if (height_eff() == 0) phase_q = DEC_DONE;
         else phase_q = DEC_TABLE;
      end
      case (phase_q)
         DEC_TABLE: begin
            if (pos[0] == 1'b0) hi_q = b;
            else begin
               idx = pos >> 1;
               if (idx < TblDepth) row_len_mem[idx] = {hi_q[7:0], b};
            end
            if (pos + 1 >= longint'(plane_count()) * height_eff() * 2) begin
               plane_q = 0;
               row_q = 0;
               phase_q = DEC_COUNT;
               fetch_row();
               skip_empty();
            end
         end
         DEC_COUNT: begin
            if (pos + 1 >= lenl) begin
               phase_q = DEC_FAIL;
               err_q = ST_TRUNC;
            end else if (b <= 127) begin
               cnt = b + 1;
               budget_q -= cnt + 1;
               if (col_q + cnt > stride_eff()) begin
                  next_row();
                  skip_empty();
               end else if (lenl - (pos + 1) < cnt) begin
                  phase_q = DEC_FAIL;
                  err_q = ST_TRUNC;
               end else begin
                  left_q = cnt;
                  phase_q = DEC_LITERAL;
               end
            end else begin
               cnt = 257 - b;
               if (col_q + cnt > stride_eff()) begin
                  next_row();
                  skip_empty();
               end else begin
                  left_q = cnt;
                  phase_q = DEC_REPEAT;
               end
            end
         end
         DEC_LITERAL, DEC_REPEAT: begin
            wv = 1;
            r.plane = map_plane(plane_q);
            r.row = row_q;
            r.column = col_q;
            r.pixel_value = b;
            if (phase_q == DEC_LITERAL) begin
               r.run_length = 1;
               col_q++;
               left_q = (left_q - 1) & 8'hFF;
               if (left_q == 0) begin
                  phase_q = DEC_COUNT;
                  skip_empty();
               end
            end else begin
               r.run_length = left_q;
               col_q += left_q;
               budget_q -= 2;
               phase_q = DEC_COUNT;
               skip_empty();
            end
         end
         default: ;
      endcase
      fin = (pos + 1 >= lenl);
      pos_q = (pos + 1) & 24'hFFFFFF;
      if (!wv && !fin) return;
      r.write_valid = wv;
      r.packet_end = fin;
      if (fin) begin
         if (phase_q == DEC_FAIL) r.status = err_q;
         else if (phase_q == DEC_DONE) r.status = ST_OK;
         else r.status = ST_TRUNC;
         clear_state();
      end
      beat_q.push_back(r);
   endfunction

   function automatic void check_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
         $error("%s mismatch: expected %0d, actual %0d", name, e, a);
         fails++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (beat_q.size() == 0) begin
            $error("rsp beat with nothing expected");
            fails++;
         end else begin
            e = beat_q.pop_front();
            beats_seen++;
            if (e.write_valid) writes_seen++;
            if (e.packet_end) status_seen[e.status]++;
            check_field("write_valid", e.write_valid, rsp_write_valid);
            check_field("plane", e.plane, rsp_plane);
            check_field("row", e.row, rsp_row);
            check_field("column", e.column, rsp_column);
            check_field("run_length", e.run_length, rsp_run_length);
            check_field("pixel_value", e.pixel_value, rsp_pixel_value);
            check_field("packet_end", e.packet_end, rsp_packet_end);
            check_field("status", e.status, rsp_status);
         end
      end
      rcyc++;
      case ((rcyc / 256) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic send_byte(input logic [7:0] b, input logic [23:0] len);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_packet_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(b, len);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (beat_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_reg(input logic [1:0] idx, input int unsigned val);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val[12:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_DEPTH:  cfg_depth = val & 3;
         CSR_HEIGHT: cfg_height = val & 11'h7FF;
         CSR_WIDTH:  cfg_width = val & 13'h1FFF;
         default:    cfg_stride = val & 13'h1FFF;
      endcase
   endtask

   task automatic set_all(int unsigned d, int unsigned h, int unsigned w, int unsigned s);
      set_reg(CSR_DEPTH, d);
      set_reg(CSR_HEIGHT, h);
      set_reg(CSR_WIDTH, w);
      set_reg(CSR_STRIDE, s);
   endtask

   task automatic put16(input logic [15:0] v);
      pkt.push_back(v[15:8]);
      pkt.push_back(v[7:0]);
   endtask

   task automatic pad_to(input int n);
      while (pkt.size() < n) pkt.push_back($urandom);
   endtask

   // sends the first len bytes of pkt as one packet; optional drain at pause_at
   task automatic send_packet(input int len, input int pause_at = -1);
      for (int i = 0; i < len; i++) begin
         if (i == pause_at) drain();
         send_byte(pkt[i], len);
      end
      packets_sent++;
      pkt.delete();
   endtask

   // first beat claims a long packet so the size check passes, the rest carry len
   task automatic send_relabeled(input int len);
      for (int i = 0; i < len; i++) send_byte(pkt[i], (i == 0) ? 24'd255 : 24'(len));
      packets_sent++;
      pkt.delete();
   endtask

   // random packet for the current settings; corrupt adds noise or truncation
   task automatic make_packet(input bit corrupt, output int len);
      logic [15:0] lens[$];
      logic [7:0]  data[$];
      int unsigned col, cost, n, ops, stride, need;
      stride = stride_eff();
      for (int r = 0; r < plane_count() * height_eff(); r++) begin
         col = 0;
         cost = 0;
         ops = $urandom_range(0, 3);
         for (int k = 0; k < ops; k++) begin
            if ($urandom_range(0, 1)) begin
               n = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 128 : 8);
               if (col + n > stride) n = stride - col;
               if (n == 0) break;
               data.push_back(n - 1);
               for (int j = 0; j < n; j++) data.push_back($urandom);
               cost += n + 1;
            end else begin
               n = $urandom_range(2, ($urandom_range(0, 3) == 0) ? 129 : 10);
               if (col + n > stride) begin
                  if (stride - col < 2) break;
                  n = stride - col;
               end
               data.push_back(257 - n);
               data.push_back($urandom);
               cost += 2;
            end
            col += n;
         end
         lens.push_back(cost);
      end
      foreach (lens[i]) put16(lens[i]);
      foreach (data[i]) pkt.push_back(data[i]);
      need = plane_count() * height_eff() * (2 + 2 * ((cfg_width + 128) / 129));
      pad_to(need);
      if (pkt.size() == 0) pkt.push_back($urandom);
      len = pkt.size();
      if (corrupt) begin
         case ($urandom_range(0, 2))
            0: pkt[$urandom_range(0, len - 1)] = $urandom;
            1: len = $urandom_range(1, len);
            default: for (int i = 0; i < 8; i++) pkt[$urandom_range(0, len - 1)] = $urandom;
         endcase
      end
   endtask

   task automatic test_defaults();
      put16(16'h0002); pkt.push_back(8'h00); pkt.push_back(8'hFF);
      send_packet(4);
      pkt = '{8'h01, 8'h02, 8'h03};
      send_packet(3);
      put16(16'h0002); pkt.push_back(8'h80); pkt.push_back(8'h05);
      send_packet(4);
   endtask

   task automatic test_extremes();
      set_all(2, 1, 4096, 4096);
      put16(16'h0042); put16(16'h0081); put16(16'h0002); put16(16'h0000);
      for (int i = 0; i < 31; i++) begin
         pkt.push_back(8'h80);
         pkt.push_back(i[0] ? 8'hFF : 8'h00);
      end
      pkt.push_back(8'd161); pkt.push_back(8'hAA);
      pkt.push_back(8'h00); pkt.push_back(8'h55);
      pkt.push_back(8'd127);
      for (int i = 0; i < 128; i++) pkt.push_back(i * 2 + 1);
      pkt.push_back(8'hFF); pkt.push_back(8'hFF);
      pad_to(264);
      send_packet(264);
   endtask

   task automatic test_truncation();
      set_all(0, 1, 1, 8);
      put16(16'h0010); pkt.push_back(8'h00); pkt.push_back(8'h07); pkt.push_back(8'h01);
      send_packet(5);
      put16(16'h0010); pkt.push_back(8'h05); pkt.push_back(8'h11); pkt.push_back(8'h22);
      send_packet(5);
      put16(16'h0010); pkt.push_back(8'h00); pkt.push_back(8'h33);
      send_packet(4);
      // budget wraps below zero, row keeps going until the packet ends
      put16(16'h0001); pkt.push_back(8'h00); pkt.push_back(8'h44);
      pkt.push_back(8'hFE); pkt.push_back(8'h66);
      send_packet(6);
      // length changes while the table is still arriving
      set_all(2, 4, 1, 8);
      for (int i = 0; i < 5; i++) send_byte(i, 24'hFFFFFF);
      send_byte(8'h09, 24'd6);
      packets_sent++;
   endtask

   task automatic test_rows();
      set_all(0, 2, 1, 4);
      put16(16'h0002); put16(16'h0002);
      pkt.push_back(8'h80); pkt.push_back(8'h77); pkt.push_back(8'h00); pkt.push_back(8'h78);
      send_packet(8);
      set_reg(CSR_HEIGHT, 3);
      put16(16'h0000); put16(16'h0002); put16(16'h0000);
      pkt.push_back(8'h00); pkt.push_back(8'h79);
      pad_to(12);
      send_packet(12);
      set_all(3, 0, 1, 0);
      pkt = '{8'h12, 8'h34, 8'h56};
      send_packet(3);
      set_reg(CSR_HEIGHT, 1);
      put16(16'h0002); pkt.push_back(8'h00); pkt.push_back(8'h7A);
      send_packet(4);
      set_reg(CSR_STRIDE, 8191);
      put16(16'h0002); pkt.push_back(8'h00); pkt.push_back(8'h7B);
      send_packet(4);
   endtask

   task automatic test_tall_image();
      // height saturates to 1024 rows: 5000 bytes pass the size check
      set_all(0, 2047, 1, 16);
      send_byte(8'h00, 24'd5000);
      send_byte(8'h08, 24'd2);
      packets_sent++;
      set_reg(CSR_HEIGHT, 1024);
      send_byte(8'h00, 24'd4095);
      send_byte(8'h08, 24'd2);
      packets_sent++;
      // long run of empty rows, sender waits for all beats mid-packet
      set_reg(CSR_HEIGHT, 8);
      for (int r = 0; r < 8; r++) put16((r == 0 || r == 7) ? 2 : 0);
      pkt.push_back(8'h00); pkt.push_back(8'hC3);
      pkt.push_back(8'h00); pkt.push_back(8'h3C);
      pad_to(32);
      send_packet(32, 20);
      // packet ends while trailing empty rows are still being skipped
      set_reg(CSR_HEIGHT, 4);
      put16(16'h0002); put16(16'h0000); put16(16'h0000); put16(16'h0000);
      pkt.push_back(8'h00); pkt.push_back(8'h79);
      send_relabeled(10);
      put16(16'h0002); put16(16'h0000); put16(16'h0002); put16(16'h0000);
      pkt.push_back(8'h00); pkt.push_back(8'h7C);
      send_relabeled(10);
      put16(16'h0000); put16(16'h0000); put16(16'h0000); put16(16'h0000);
      send_relabeled(8);
   endtask

   task automatic test_random();
      int len, start;
      start = items_sent;
      while (items_sent - start < 900) begin
         set_all($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2), $urandom_range(1, 3),
                 $urandom_range(1, 400),
                 $urandom_range(0, 4) == 0 ? 4096 : $urandom_range(1, 64));
         repeat ($urandom_range(2, 6)) begin
            make_packet($urandom_range(0, 4) == 0, len);
            send_packet(len, $urandom_range(0, 7) == 0 ? len / 2 : -1);
         end
      end
   endtask

   initial begin
      clear_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_extremes();
      test_truncation();
      test_rows();
      test_tall_image();
      test_random();
      drain();
      repeat (100) @(posedge clock);
      $display("covered %0d packets, %0d bytes, %0d rsp beats (%0d pixel writes)",
               packets_sent, items_sent, beats_seen, writes_seen);
      $display("packet status: ok %0d, too short %0d, truncated %0d",
               status_seen[0], status_seen[1], status_seen[2]);
      if (fails == 0) begin
         $display("planar_packbits_row_decoder_unit regression: pass");
      end else begin
         $display("planar_packbits_row_decoder_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("planar_packbits_row_decoder_unit regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
